>>> rtl/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared constants and types for the changer frame receiver: byte codes,
// counter sizing, command codes and the result item layout.
// ----------------------------------------------------------------------------
package cfr_pkg;

   // receive buffer size in bytes (frame abandoned when the count reaches it)
   localparam int BUFFER_BYTES = 32;
   localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
   // compare width for declared length + 4 (8-bit length, 9-bit sum)
   localparam int CMP_W        = 9;

   localparam logic [7:0] ACK_BYTE    = 8'hC5;
   localparam logic [7:0] HEADER_BYTE = 8'h3D;

   localparam logic [7:0] OP_VERSION  = 8'h31;
   localparam logic [7:0] OP_PLAY     = 8'h13;
   localparam logic [7:0] OP_PAUSE    = 8'h1C;
   localparam logic [7:0] OP_STANDBY  = 8'h19;
   localparam logic [7:0] OP_DISC     = 8'h24;
   localparam logic [7:0] OP_NEXT     = 8'h17;
   localparam logic [7:0] OP_MODE     = 8'h2C;
   localparam logic [7:0] OP_PREV     = 8'h22;
   localparam logic [7:0] ARG_ONE     = 8'h01;
   localparam logic [7:0] ARG_TWO     = 8'h02;
   localparam logic [7:0] ARG_ENTER   = 8'hFF;
   localparam logic [7:0] ARG_EXIT    = 8'h00;

   localparam logic [7:0] LEN_ONE     = 8'd1;
   localparam logic [7:0] LEN_TWO     = 8'd2;
   localparam logic [7:0] LEN_THREE   = 8'd3;
   localparam logic [7:0] LEN_VERSION = 8'd7;

   // frame positions, counted from the header at zero
   localparam logic [CNT_W-1:0] POS_IDLE  = CNT_W'(0);
   localparam logic [CNT_W-1:0] POS_SEQ   = CNT_W'(1);
   localparam logic [CNT_W-1:0] POS_LEN   = CNT_W'(2);
   localparam logic [CNT_W-1:0] POS_HEAD0 = CNT_W'(3);
   localparam logic [CNT_W-1:0] POS_HEAD1 = CNT_W'(4);
   localparam logic [CNT_W-1:0] POS_HEAD2 = CNT_W'(5);
   localparam logic [CNT_W-1:0] POS_MIN_END = CNT_W'(4);
   localparam logic [CNT_W-1:0] POS_LIMIT = CNT_W'(BUFFER_BYTES);

   typedef enum logic [3:0] {
      CMD_NONE    = 4'd0,
      CMD_VERSION = 4'd1,
      CMD_PLAY    = 4'd2,
      CMD_PAUSE   = 4'd3,
      CMD_STANDBY = 4'd4,
      CMD_DISC    = 4'd5,
      CMD_NEXT    = 4'd6,
      CMD_PREV    = 4'd7,
      CMD_ENTER   = 4'd8,
      CMD_EXIT    = 4'd9
   } cmd_type;

   typedef struct packed {
      logic       ack_seen;
      logic       frame_done;
      logic       frame_good;
      logic       frame_abandoned;
      cmd_type    command_code;
      logic [7:0] frame_sequence;
      logic [4:0] frame_length;
   } rsp_type;

endpackage

>>> rtl/cfr_if.sv
// ----------------------------------------------------------------------------
// cfr_if
// Valid/ready channels of the changer frame receiver: received bytes in,
// per-byte status items out.
// ----------------------------------------------------------------------------
interface cfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_rsp_if;
   logic       valid;
   logic       ready;
   logic       ack_seen;
   logic       frame_done;
   logic       frame_good;
   logic       frame_abandoned;
   logic [3:0] command_code;
   logic [7:0] frame_sequence;
   logic [4:0] frame_length;

   modport source (output valid, output ack_seen, output frame_done, output frame_good,
                   output frame_abandoned, output command_code, output frame_sequence,
                   output frame_length, input ready);
   modport sink   (input valid, input ack_seen, input frame_done, input frame_good,
                   input frame_abandoned, input command_code, input frame_sequence,
                   input frame_length, output ready);
endinterface

>>> rtl/cfr_in_stage.sv
// ----------------------------------------------------------------------------
// cfr_in_stage
// Input register: captures one received byte and holds it until the parser
// takes it.
// ----------------------------------------------------------------------------
module cfr_in_stage (
   input  logic       clock,
   input  logic       reset,
   cfr_req_if.sink    req,
   input  logic       take,
   output logic       byte_valid,
   output logic [7:0] byte_data
);
   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;
   logic [7:0] data_in;
   logic       load;

   assign req.ready = !valid_ff || take;
   assign load      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = req.rx_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;
endmodule

>>> rtl/cfr_parser.sv
// ----------------------------------------------------------------------------
// cfr_parser
// Frame state and per-byte decode: header hunt, sequence and length capture,
// running XOR, completion, checksum test, command decode and overflow drop.
// ----------------------------------------------------------------------------
module cfr_parser (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      byte_data,
   output cfr_pkg::rsp_type result
);
   import cfr_pkg::*;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] count_step;
   logic [7:0]       xor_ff;
   logic [7:0]       xor_in;
   logic [7:0]       seq_ff;
   logic [7:0]       seq_in;
   logic [7:0]       len_ff;
   logic [7:0]       len_in;
   logic [7:0]       head_ff [3];
   logic [7:0]       head_in [3];
   logic             at_end;
   rsp_type          res;

   function automatic cmd_type decode_cmd(input logic [7:0] len, input logic [7:0] p0,
                                          input logic [7:0] p1, input logic [7:0] p2);
      cmd_type cmd;
      cmd = CMD_NONE;
      case (len)
         LEN_VERSION: if (p0 == OP_VERSION) cmd = CMD_VERSION;
         LEN_ONE: begin
            if (p0 == OP_PLAY)         cmd = CMD_PLAY;
            else if (p0 == OP_PAUSE)   cmd = CMD_PAUSE;
            else if (p0 == OP_STANDBY) cmd = CMD_STANDBY;
            else if (p0 == OP_DISC)    cmd = CMD_DISC;
         end
         LEN_TWO: begin
            if (p0 == OP_NEXT && p1 == ARG_ONE)        cmd = CMD_NEXT;
            else if (p0 == OP_MODE && p1 == ARG_ENTER) cmd = CMD_ENTER;
            else if (p0 == OP_MODE && p1 == ARG_EXIT)  cmd = CMD_EXIT;
         end
         LEN_THREE: begin
            if (p0 == OP_PREV && p1 == ARG_ONE && p2 == ARG_TWO) cmd = CMD_PREV;
         end
         default: cmd = CMD_NONE;
      endcase
      return cmd;
   endfunction

   assign count_step = count_ff + CNT_W'(1);
   // the length register is settled by the time a frame can end
   assign at_end = (count_step >= POS_MIN_END) &&
                   (CMP_W'(count_step) == ({1'b0, len_ff} + CMP_W'(4)));

   always_comb begin
      res      = '0;
      count_in = count_ff;
      xor_in   = xor_ff;
      seq_in   = seq_ff;
      len_in   = len_ff;
      head_in  = head_ff;
      if (count_ff == POS_IDLE) begin
         if (byte_data == ACK_BYTE) begin
            res.ack_seen = 1'b1;
         end else if (byte_data == HEADER_BYTE) begin
            count_in = POS_SEQ;
            xor_in   = byte_data;
         end
      end else begin
         unique case (count_ff)
            POS_SEQ:   seq_in     = byte_data;
            POS_LEN:   len_in     = byte_data;
            POS_HEAD0: head_in[0] = byte_data;
            POS_HEAD1: head_in[1] = byte_data;
            POS_HEAD2: head_in[2] = byte_data;
            default: ;
         endcase
         count_in = count_step;
         if (at_end) begin
            res.frame_done     = 1'b1;
            res.frame_sequence = seq_ff;
            res.frame_length   = len_ff[4:0];
            if (byte_data == xor_ff) begin
               res.frame_good   = 1'b1;
               res.command_code = decode_cmd(len_ff, head_ff[0], head_ff[1], head_ff[2]);
            end
            count_in = POS_IDLE;
            xor_in   = '0;
         end else begin
            xor_in = xor_ff ^ byte_data;
         end
      end
      // drop a frame that would overrun the buffer
      if (count_in >= POS_LIMIT) begin
         res.frame_abandoned = 1'b1;
         count_in            = POS_IDLE;
         xor_in              = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= POS_IDLE;
         xor_ff   <= '0;
      end else if (step) begin
         count_ff <= count_in;
         xor_ff   <= xor_in;
      end
      if (step) begin
         seq_ff  <= seq_in;
         len_ff  <= len_in;
         head_ff <= head_in;
      end
   end

   assign result = res;
endmodule

>>> rtl/cfr_out_stage.sv
// ----------------------------------------------------------------------------
// cfr_out_stage
// Result register: holds one status item until the consumer takes it.
// ----------------------------------------------------------------------------
module cfr_out_stage (
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  cfr_pkg::rsp_type result,
   output logic            room,
   cfr_rsp_if.source       rsp
);
   import cfr_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;
   rsp_type data_in;

   assign room = !valid_ff || rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp.valid           = valid_ff;
   assign rsp.ack_seen        = data_ff.ack_seen;
   assign rsp.frame_done      = data_ff.frame_done;
   assign rsp.frame_good      = data_ff.frame_good;
   assign rsp.frame_abandoned = data_ff.frame_abandoned;
   assign rsp.command_code    = 4'(data_ff.command_code);
   assign rsp.frame_sequence  = data_ff.frame_sequence;
   assign rsp.frame_length    = data_ff.frame_length;
endmodule

>>> rtl/changer_frame_receiver_core.sv
// ----------------------------------------------------------------------------
// changer_frame_receiver_core
// Serial frame receiver for a disc changer link: one status item per byte.
//
//   channel  direction  payload                                   handshake
//   req_ch   in         rx_byte[7:0]                              valid/ready
//   rsp_ch   out        ack_seen, frame_done, frame_good,         valid/ready
//                       frame_abandoned, command_code[3:0],
//                       frame_sequence[7:0], frame_length[4:0]
//
// One byte per cycle sustained while rsp_ch takes results; an accepted byte is
// loaded into the input register and then parsed into the result register.
// The frame counter and running XOR update in the cycle a byte is parsed.
// Reset is synchronous and clears the frame counter, XOR and valid flags.
// A stalled result holds the parser; the input register then fills and
// req_ch.ready drops.
// ----------------------------------------------------------------------------
module changer_frame_receiver_core (
   input  logic      clock,
   input  logic      reset,
   cfr_req_if.sink   req_ch,
   cfr_rsp_if.source rsp_ch
);
   import cfr_pkg::*;

   logic       byte_valid;
   logic [7:0] byte_data;
   logic       room;
   logic       step;
   rsp_type    result;

   assign step = byte_valid && room;

   cfr_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .take       (step),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   cfr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .byte_data (byte_data),
      .result    (result)
   );

   cfr_out_stage u_out (
      .clock  (clock),
      .reset  (reset),
      .load   (step),
      .result (result),
      .room   (room),
      .rsp    (rsp_ch)
   );

   // a parsed byte always lands in the result register
   a_step_lands: assert property (@(posedge clock) disable iff (reset)
      step |=> rsp_ch.valid)
      else $error("parsed byte did not produce a result");

   a_good_is_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.frame_good) |-> rsp_ch.frame_done)
      else $error("good frame without completion");

   a_cmd_needs_good: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.command_code != 4'(CMD_NONE)) |-> rsp_ch.frame_good)
      else $error("command decoded from a bad frame");

   a_fields_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.frame_done) |->
         (rsp_ch.frame_sequence == 8'd0 && rsp_ch.frame_length == 5'd0))
      else $error("frame fields set without a completed frame");

   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.ack_seen && (rsp_ch.frame_done || rsp_ch.frame_abandoned)))
      else $error("acknowledge reported inside a frame");
endmodule
